// ----- src/lcs_pkg.sv -----
// Shared types, codes and helpers of the storage command latency statistics unit.
package lcs_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int SUM_W = 64;
   localparam int CNT_W = 32;
   localparam int IN_LAT_W = 32;
   localparam int NUM_CLASSES = 7;

   localparam logic [1:0] REQ_COMPLETE = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [2:0] CLS_ALL = 3'd0;
   localparam logic [2:0] CLS_READ = 3'd1;
   localparam logic [2:0] CLS_WRITE = 3'd2;
   localparam logic [2:0] CLS_DISCARD = 3'd3;
   localparam logic [2:0] CLS_FLUSH = 3'd4;
   localparam logic [2:0] CLS_SECURITY = 3'd5;
   localparam logic [2:0] CLS_OTHER = 3'd6;
   localparam logic [2:0] CLS_NONE = 3'd7;

   localparam logic [1:0] KIND_MIN = 2'd0;
   localparam logic [1:0] KIND_MAX = 2'd1;
   localparam logic [1:0] KIND_AVG = 2'd2;
   localparam logic [1:0] KIND_SUM = 2'd3;

   localparam logic [7:0] OPC_READ_10 = 8'h28;
   localparam logic [7:0] OPC_READ_16 = 8'h88;
   localparam logic [7:0] OPC_WRITE_10 = 8'h2A;
   localparam logic [7:0] OPC_WRITE_16 = 8'h8A;
   localparam logic [7:0] OPC_UNMAP = 8'h42;
   localparam logic [7:0] OPC_SYNC_CACHE = 8'h35;
   localparam logic [7:0] OPC_SEC_IN = 8'hA2;
   localparam logic [7:0] OPC_SEC_OUT = 8'hB5;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_TALLY,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASS,
      ST_QUERY,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [2:0]           cls;
      logic [1:0]           kind;
      logic [IN_LAT_W-1:0]  latency;
   } work_item_type;

   typedef struct packed {
      logic [2:0]       class_seen;
      logic             tallied;
      logic [SUM_W-1:0] stat_value;
   } rsp_type;

   function automatic logic [2:0] classify(input logic [7:0] opcode);
      logic [2:0] cls;
      case (opcode)
         OPC_READ_10, OPC_READ_16: cls = CLS_READ;
         OPC_WRITE_10, OPC_WRITE_16: cls = CLS_WRITE;
         OPC_UNMAP: cls = CLS_DISCARD;
         OPC_SYNC_CACHE: cls = CLS_FLUSH;
         OPC_SEC_IN, OPC_SEC_OUT: cls = CLS_SECURITY;
         default: cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

// ----- src/lcs_front.sv -----
// Front end: accepts request beats and turns them into classified commands.
module lcs_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // has_command, opcode[7:0], latency_us[31:0], stat_class[2:0], stat_kind[1:0], zero pad
   input  logic [lcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [lcs_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                             queue_full,
   output logic                             push,
   output lcs_pkg::work_item_type           cmd
);
   import lcs_pkg::*;

   logic             has_command;
   logic [7:0]       opcode;
   logic [2:0]       stat_class;
   logic [1:0]       stat_kind;

   assign has_command = req_tdata[0];
   assign opcode = req_tdata[8:1];
   assign stat_class = req_tdata[43:41];
   assign stat_kind = req_tdata[45:44];

   assign req_tready = !queue_full;
   assign push = req_tvalid && !queue_full;

   always_comb begin
      cmd.latency = req_tdata[40:9];
      cmd.kind = stat_kind;
      cmd.cls = CLS_ALL;
      cmd.op = OP_NONE;
      case (req_tuser)
         REQ_COMPLETE: begin
            cmd.op = has_command ? OP_TALLY : OP_NONE;
            cmd.cls = classify(opcode);
         end
         REQ_QUERY: begin
            cmd.op = OP_QUERY;
            cmd.cls = stat_class;
         end
         REQ_CLEAR: begin
            cmd.op = OP_CLEAR;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

// ----- src/lcs_fifo.sv -----
// Short command queue between the front end and the back end.
module lcs_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lcs_pkg::work_item_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output lcs_pkg::work_item_type head
);
   import lcs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   work_item_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W_Q-1:0]   count_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W_Q-1:0]   count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = (count_ff == CNT_W_Q'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W_Q'(DEPTH))
      else $error("queue count exceeds its depth");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> (count_ff == CNT_W_Q'(DEPTH)))
      else $error("queue lost an entry while full");
   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on a pop");

endmodule

// ----- src/lcs_div.sv -----
// Restoring divider for the average, one quotient bit per cycle.
module lcs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lcs_pkg::SUM_W-1:0]   dividend,
   input  logic [lcs_pkg::CNT_W-1:0]   divisor,
   output logic                        busy,
   output logic [lcs_pkg::SUM_W-1:0]   quotient
);
   import lcs_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dsr_ff;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    trial;
   logic [CNT_W-1:0]  rem_in;
   logic [SUM_W-1:0]  quo_in;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial = shifted - {1'b0, dsr_ff};

   always_comb begin
      if (!trial[CNT_W]) begin
         rem_in = trial[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/lcs_back.sv -----
// Back end: statistics tables, update and query sequencer, and the result register.
module lcs_back #(
   parameter int LATENCY_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  lcs_pkg::work_item_type           head,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // stat_value[63:0], tallied, class_seen[2:0], zero pad
   output logic [lcs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import lcs_pkg::*;

   localparam int LAT_W = LATENCY_BITS;

   logic [CNT_W-1:0]       cnt_ff [NUM_CLASSES];
   logic [SUM_W-1:0]       sum_ff [NUM_CLASSES];
   logic [LAT_W-1:0]       min_ff [NUM_CLASSES];
   logic [LAT_W-1:0]       max_ff [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] vld_ff;

   state_type        state_ff;
   state_type        state_in;
   work_item_type    cmd_ff;
   logic             cmd_load;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          res;
   logic             emit;
   logic             out_free;
   logic             upd_we;
   logic             clr;
   logic             div_start;
   logic             div_busy;
   logic [SUM_W-1:0] div_quo;

   logic [2:0]       idx;
   logic             idx_ok;
   logic [IN_LAT_W-1:0] lat_src;
   logic [63:0]      lat_full;
   logic [LAT_W-1:0] lat;
   logic [CNT_W-1:0] e_cnt;
   logic [SUM_W-1:0] e_sum;
   logic [LAT_W-1:0] e_min;
   logic [LAT_W-1:0] e_max;
   logic [CNT_W-1:0] n_cnt;
   logic [SUM_W-1:0] n_sum;
   logic [LAT_W-1:0] n_min;
   logic [LAT_W-1:0] n_max;
   logic [SUM_W-1:0] q_value;

   assign idx = (state_ff == ST_IDLE) ? CLS_ALL : cmd_ff.cls;
   assign idx_ok = (idx != CLS_NONE);
   assign lat_src = (state_ff == ST_IDLE) ? head.latency : cmd_ff.latency;
   assign lat_full = 64'(lat_src);
   assign lat = lat_full[LAT_W-1:0];

   always_comb begin
      e_cnt = '0;
      e_sum = '0;
      e_min = '0;
      e_max = '0;
      if (idx_ok) begin
         if (vld_ff[idx]) begin
            e_cnt = cnt_ff[idx];
            e_sum = sum_ff[idx];
            e_min = min_ff[idx];
            e_max = max_ff[idx];
         end
      end
   end

   assign n_cnt = (e_cnt != '1) ? e_cnt + 1'b1 : e_cnt;
   assign n_sum = e_sum + SUM_W'(lat);
   assign n_min = (e_min == '0 || e_min > lat) ? lat : e_min;
   assign n_max = (e_max < lat) ? lat : e_max;

   always_comb begin
      q_value = '0;
      if (idx_ok) begin
         case (cmd_ff.kind)
            KIND_MIN: q_value = SUM_W'(e_min);
            KIND_MAX: q_value = SUM_W'(e_max);
            KIND_AVG: q_value = '0;
            KIND_SUM: q_value = e_sum;
            default: q_value = '0;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      cmd_load = 1'b0;
      upd_we = 1'b0;
      clr = 1'b0;
      emit = 1'b0;
      div_start = 1'b0;
      res = '0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head.op)
                  OP_TALLY: begin
                     pop = 1'b1;
                     cmd_load = 1'b1;
                     upd_we = 1'b1;
                     state_in = ST_CLASS;
                  end
                  OP_QUERY: begin
                     pop = 1'b1;
                     cmd_load = 1'b1;
                     state_in = ST_QUERY;
                  end
                  OP_CLEAR: begin
                     if (out_free) begin
                        pop = 1'b1;
                        clr = 1'b1;
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        pop = 1'b1;
                        emit = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_CLASS: begin
            if (out_free) begin
               upd_we = 1'b1;
               emit = 1'b1;
               res.tallied = 1'b1;
               res.class_seen = cmd_ff.cls;
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (idx_ok && cmd_ff.kind == KIND_AVG && e_cnt != '0) begin
               div_start = 1'b1;
               state_in = ST_DIVIDE;
            end else if (out_free) begin
               emit = 1'b1;
               res.stat_value = q_value;
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (!div_busy && out_free) begin
               emit = 1'b1;
               res.stat_value = div_quo;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clr) begin
            vld_ff <= '0;
         end else if (upd_we) begin
            vld_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_load) begin
         cmd_ff <= head;
      end
      if (emit) begin
         rsp_ff <= res;
      end
      if (upd_we) begin
         cnt_ff[idx] <= n_cnt;
         sum_ff[idx] <= n_sum;
         min_ff[idx] <= n_min;
         max_ff[idx] <= n_max;
      end
   end

   lcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (e_sum),
      .divisor  (e_cnt),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

   a_tally_class: assert property (@(posedge clock) disable iff (reset)
      (emit && res.tallied) |-> (res.class_seen != CLS_ALL && res.class_seen != CLS_NONE))
      else $error("tallied result carries an invalid class");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      clr |=> (vld_ff == '0))
      else $error("clear left an entry valid");
   a_class_is_tally: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLASS) |-> (cmd_ff.op == OP_TALLY))
      else $error("class update without a tally command");

endmodule

// ----- src/storage_cmd_latency_stats_top.sv -----
// Top level of the storage command latency statistics unit.
// Request beats pass through a two-entry command queue into a sequencer that owns the tables.
// A counted completion does one read-modify-write of the all-commands entry, then one of its
// class entry on the shared update path once the result register is free. A min, max or sum
// query, or an average over an empty class, is loaded in the idle state and answered from
// the query state. Other average queries wait in the divide state for the divider, which
// produces one quotient bit per cycle. Clear, ignored completions and unused request types
// are handled in idle; the result register lets the back end go on while a result waits.
module storage_cmd_latency_stats_top #(
   parameter int LATENCY_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // has_command, opcode[7:0], latency_us[31:0], stat_class[2:0], stat_kind[1:0], zero pad
   input  logic [lcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [lcs_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // stat_value[63:0], tallied, class_seen[2:0], zero pad
   output logic [lcs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import lcs_pkg::*;

   logic          push;
   logic          queue_full;
   work_item_type push_cmd;
   logic          pop;
   logic          head_valid;
   work_item_type head;

   lcs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   lcs_fifo #(
      .DEPTH (2)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   lcs_back #(
      .LATENCY_BITS (LATENCY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
